/* design/hbd_pkg.sv */
// ----------------------------------------------------------------------------
// HDLC bit deframer package
// Shared types, constants and the FCS byte update used by the deframer.
// ----------------------------------------------------------------------------
package hbd_pkg;

  localparam int unsigned LEN_W = 10;
  localparam int unsigned Q_DEPTH = 2;

  localparam logic [7:0] FLAG_BYTE = 8'h7e;
  localparam logic [15:0] FCS_POLY = 16'h8408;
  localparam logic [15:0] FCS_INIT = 16'hffff;
  localparam logic [15:0] FCS_GOOD = 16'hf0b8;
  localparam logic [LEN_W-1:0] MAX_FRAME_RESET = LEN_W'(330);

  typedef enum logic [1:0] {
    MODE_SYNC = 2'd0,
    MODE_WAIT = 2'd1,
    MODE_RECV = 2'd2
  } mode_t;

  typedef struct packed {
    logic rx_bit;
    logic flag;
  } q_entry_t;

  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

  function automatic logic [15:0] fcs_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      crc = crc[0] ? ((crc >> 1) ^ FCS_POLY) : (crc >> 1);
    end
    return crc;
  endfunction

endpackage

/* design/hbd_in_if.sv */
// ----------------------------------------------------------------------------
// Line bit channel
// Valid/ready channel carrying one received line bit per item.
// ----------------------------------------------------------------------------
interface hbd_in_if;
  logic valid;
  logic ready;
  logic rx_bit;

  modport source (output valid, output rx_bit, input ready);
  modport sink (input valid, input rx_bit, output ready);
  modport mon (input valid, input rx_bit, input ready);
endinterface

/* design/hbd_out_if.sv */
// ----------------------------------------------------------------------------
// Frame result channel
// Valid/ready channel carrying frame bytes and end of frame results.
// ----------------------------------------------------------------------------
interface hbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       end_of_frame;
  logic       frame_good;

  modport source (output valid, output byte_value, output end_of_frame,
                  output frame_good, input ready);
  modport sink (input valid, input byte_value, input end_of_frame,
                input frame_good, output ready);
  modport mon (input valid, input byte_value, input end_of_frame,
               input frame_good, input ready);
endinterface

/* design/hbd_front.sv */
// ----------------------------------------------------------------------------
// HDLC deframer front end
// Counts runs of ones, drops stuffed zeros and marks flag bits.
// ----------------------------------------------------------------------------
module hbd_front (
  input  logic             clk,
  input  logic             rst_n,
  hbd_in_if.sink           in_ch,
  input  logic             q_not_full,
  output hbd_pkg::q_push_t q_push
);
  import hbd_pkg::*;

  logic [2:0] ones_r;
  logic [2:0] ones_nxt;
  logic       accept;
  logic       stuffed;

  assign in_ch.ready = q_not_full;
  assign accept      = in_ch.valid && q_not_full;
  assign stuffed     = !in_ch.rx_bit && (ones_r == 3'd5);

  always_comb begin
    ones_nxt = ones_r;
    if (accept) begin
      if (in_ch.rx_bit) begin
        ones_nxt = (ones_r == 3'd7) ? ones_r : ones_r + 3'd1;
      end else begin
        ones_nxt = 3'd0;
      end
    end
  end

  assign q_push.push         = accept && !stuffed;
  assign q_push.entry.rx_bit = in_ch.rx_bit;
  assign q_push.entry.flag   = !in_ch.rx_bit && (ones_r == 3'd6);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ones_r <= 3'd0;
    end else begin
      ones_r <= ones_nxt;
    end
  end

endmodule

/* design/hbd_queue.sv */
// ----------------------------------------------------------------------------
// HDLC deframer bit queue
// Short first-in first-out queue of classified bits between the two ends.
// ----------------------------------------------------------------------------
module hbd_queue #(
  parameter int unsigned DEPTH = hbd_pkg::Q_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  hbd_pkg::q_push_t  q_push,
  input  logic              pop,
  output logic              not_full,
  output logic              not_empty,
  output hbd_pkg::q_entry_t head
);
  import hbd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  q_entry_t           mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic               do_push;
  logic               do_pop;

  assign not_full  = (count_r != CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = q_push.push && not_full;
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    count_nxt = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= q_push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* design/hbd_back.sv */
// ----------------------------------------------------------------------------
// HDLC deframer back end
// Flag hunt, byte assembly, FCS check, two-byte delay and result register.
// ----------------------------------------------------------------------------
module hbd_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_not_empty,
  input  hbd_pkg::q_entry_t         head,
  output logic                      pop,
  input  logic                      cfg_we,
  input  logic [hbd_pkg::LEN_W-1:0] cfg_data,
  hbd_out_if.source                 out_ch
);
  import hbd_pkg::*;

  mode_t             mode_r, mode_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [15:0]       fcs_r, fcs_nxt;
  logic [7:0]        dly0_r, dly0_nxt;
  logic [7:0]        dly1_r, dly1_nxt;
  logic [1:0]        fill_r, fill_nxt;
  logic [LEN_W-1:0]  max_len_r;

  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic              out_eof_r;
  logic              out_good_r;

  logic [7:0]        sh;
  logic [3:0]        cnt_inc;
  logic              res_valid;
  logic [7:0]        res_byte;
  logic              res_eof;
  logic              res_good;

  assign pop = q_not_empty && (!out_valid_r || out_ch.ready);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.byte_value   = out_byte_r;
  assign out_ch.end_of_frame = out_eof_r;
  assign out_ch.frame_good   = out_good_r;

  always_comb begin
    sh        = {head.rx_bit, shift_r[7:1]};
    cnt_inc   = cnt_r + 4'd1;
    mode_nxt  = mode_r;
    shift_nxt = shift_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    fcs_nxt   = fcs_r;
    dly0_nxt  = dly0_r;
    dly1_nxt  = dly1_r;
    fill_nxt  = fill_r;
    res_valid = 1'b0;
    res_byte  = 8'h00;
    res_eof   = 1'b0;
    res_good  = 1'b0;
    if (pop) begin
      shift_nxt = sh;
      unique case (mode_r)
        MODE_WAIT: begin
          cnt_nxt = cnt_inc;
          if (cnt_inc[3]) begin
            if (sh != FLAG_BYTE) begin
              mode_nxt = MODE_RECV;
              fcs_nxt  = fcs_byte(FCS_INIT, sh);
              len_nxt  = LEN_W'(1);
              dly0_nxt = sh;
              fill_nxt = 2'd1;
            end
            cnt_nxt = 4'd0;
          end else if (sh == FLAG_BYTE) begin
            cnt_nxt = 4'd0;
          end
        end
        MODE_RECV: begin
          cnt_nxt = cnt_inc;
          if (cnt_inc[3]) begin
            cnt_nxt = 4'd0;
            if (head.flag) begin
              mode_nxt  = MODE_WAIT;
              res_valid = 1'b1;
              res_eof   = 1'b1;
              res_good  = (len_r > LEN_W'(2)) && (fcs_r == FCS_GOOD);
              fill_nxt  = 2'd0;
            end else if (len_r < max_len_r) begin
              shift_nxt = 8'h00;
              len_nxt   = len_r + LEN_W'(1);
              fcs_nxt   = fcs_byte(fcs_r, sh);
              if (fill_r[1]) begin
                res_valid = 1'b1;
                res_byte  = dly0_r;
                dly0_nxt  = dly1_r;
                dly1_nxt  = sh;
              end else begin
                if (fill_r[0]) begin
                  dly1_nxt = sh;
                end else begin
                  dly0_nxt = sh;
                end
                fill_nxt = fill_r + 2'd1;
              end
            end else begin
              mode_nxt  = MODE_SYNC;
              res_valid = 1'b1;
              res_eof   = 1'b1;
              fill_nxt  = 2'd0;
            end
          end else if (head.flag) begin
            mode_nxt  = MODE_WAIT;
            cnt_nxt   = 4'd0;
            res_valid = 1'b1;
            res_eof   = 1'b1;
            fill_nxt  = 2'd0;
          end
        end
        default: begin
          mode_nxt = MODE_SYNC;
          if (sh == FLAG_BYTE) begin
            mode_nxt = MODE_WAIT;
            cnt_nxt  = 4'd0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_SYNC;
      shift_r   <= 8'h00;
      cnt_r     <= 4'd0;
      len_r     <= '0;
      fcs_r     <= FCS_INIT;
      fill_r    <= 2'd0;
      max_len_r <= MAX_FRAME_RESET;
    end else begin
      mode_r  <= mode_nxt;
      shift_r <= shift_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      fcs_r   <= fcs_nxt;
      fill_r  <= fill_nxt;
      if (cfg_we) begin
        max_len_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    dly0_r <= dly0_nxt;
    dly1_r <= dly1_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      out_byte_r <= res_byte;
      out_eof_r  <= res_eof;
      out_good_r <= res_good;
    end
  end

endmodule

/* design/hdlc_bit_deframer_core.sv */
// ----------------------------------------------------------------------------
// HDLC bit deframer core
// Line bits in, destuffed frame bytes and checked end of frame results out.
// ----------------------------------------------------------------------------
// The core accepts one line bit per clock cycle for as long as results are
// taken. The front end strips stuffed zeros and marks flags in the cycle a
// bit is accepted; the back end consumes one queued bit per cycle while
// results are taken, assembles bytes, updates the CRC-16/X.25 check once per
// byte and holds each result in an output register, so a result passes
// through the queue and the output register after the bit that completes it
// is accepted. The queue of QUEUE_DEPTH entries between the two ends sets
// how many bits are taken while the output is stalled. Frame bytes are
// released two bytes late, so the FCS bytes never appear. The frame length
// limit may be written only while no bit is in flight.
module hdlc_bit_deframer_core #(
  parameter int unsigned QUEUE_DEPTH = hbd_pkg::Q_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  hbd_in_if.sink                    in_ch,
  hbd_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [hbd_pkg::LEN_W-1:0] cfg_data
);
  import hbd_pkg::*;

  q_push_t  q_push;
  q_entry_t q_head;
  logic     q_not_full;
  logic     q_not_empty;
  logic     q_pop;

  hbd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_not_full (q_not_full),
    .q_push     (q_push)
  );

  hbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_push    (q_push),
    .pop       (q_pop),
    .not_full  (q_not_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  hbd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .head        (q_head),
    .pop         (q_pop),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .out_ch      (out_ch)
  );

endmodule

/* design/hbd_checker.sv */
// ----------------------------------------------------------------------------
// HDLC bit deframer checker
// Port-level checks on the deframer core, bound to the top level.
// ----------------------------------------------------------------------------
module hbd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte_value,
  input logic       out_end_of_frame,
  input logic       out_frame_good
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte_value)
      && $stable(out_end_of_frame) && $stable(out_frame_good))
    else $error("stalled result changed");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // While results are taken the queue drains, so the input is never held off.
  a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |=> in_ready)
    else $error("input stalled although the output was ready");

endmodule

bind hdlc_bit_deframer_core hbd_checker u_hbd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_byte_value   (out_ch.byte_value),
  .out_end_of_frame (out_ch.end_of_frame),
  .out_frame_good   (out_ch.frame_good)
);
